>>> design/rls_pkg.sv
`default_nettype none

package rls_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned PRIO_W  = 4;
  localparam int unsigned NEED_W  = 8;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_INS_PRIO,
    OP_INS_TAIL,
    OP_REMOVE,
    OP_ROTATE,
    OP_REINSERT,
    OP_HEAD_WR,
    OP_SORT_EVEN,
    OP_SORT_ODD
  } rls_op_e;

endpackage

`default_nettype wire

>>> design/ready_list_scheduler.sv
`default_nettype none

// Ready-list scheduler: a row of list cells, slot 0 is the head.
// Command channel: an item (mode, need_time, priority_req) is taken on a
// rising edge with start high and busy low. mode 1 adds a process, mode 0
// runs the head entry for one time unit.
// Result channel: result_valid_o is high for exactly one cycle, registered
// from state EXEC with the result word; the result ports hold the word in that cycle.
// The receiver cannot stall, so no word is ever held back.
// busy is high in state EXEC, so a new item is taken only after the last one
// has left it. A priority-mode tick on a list reordered under round robin adds
// an odd-even transposition sort over the cells, with busy high throughout;
// the result word is still registered from state EXEC, not after the sort.
// Config channel: cfg_valid_i/cfg_ready_o write the policy bit
// (0 priority with aging, 1 round robin); it applies from the next item.
// Reset: list empty, identifier counter and policy zero, no result pending.

module ready_list_scheduler #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        mode_i,
  input  wire logic [rls_pkg::NEED_W-1:0]  need_time_i,
  input  wire logic [rls_pkg::PRIO_W-1:0]  priority_req_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_policy_i,
  output logic                             result_valid_o,
  output logic                             ran_o,
  output logic [rls_pkg::ID_W-1:0]         run_id_o,
  output logic [rls_pkg::NEED_W-1:0]       run_remaining_o,
  output logic                             finished_o,
  output logic                             add_refused_o,
  output logic [rls_pkg::COUNT_W-1:0]      ready_count_o
);
  import rls_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_PROCS + 1);
  localparam int unsigned PhW    = $clog2(MAX_PROCS);
  localparam int unsigned EntW   = ID_W + 2 * TIME_BITS + PRIO_W;
  localparam int unsigned TMaxI  = (2 ** TIME_BITS) - 1;
  localparam logic [CntW-1:0] FullC    = CntW'(MAX_PROCS);
  localparam logic [PhW-1:0]  LastPhC  = PhW'(MAX_PROCS - 1);
  localparam logic [TIME_BITS-1:0] TMaxC = TIME_BITS'(TMaxI);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic                 mode_q;
  logic [TIME_BITS-1:0] need_q;
  logic [PRIO_W-1:0]    prio_q;
  logic                 policy_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [ID_W-1:0]      next_id_q, next_id_d;
  logic                 sorted_q, sorted_d;
  logic [PhW-1:0]       phase_q, phase_d;

  logic                 strobe_q;
  logic                 ran_q, ran_d;
  logic [ID_W-1:0]      rid_q, rid_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic                 fin_q, fin_d;
  logic                 ref_q, ref_d;

  logic                 accept;
  logic [TIME_BITS-1:0] need_sat;
  rls_op_e              op;
  logic [EntW-1:0]      ent_bus;
  logic [EntW-1:0]      cell_ent [MAX_PROCS];
  logic                 carry [MAX_PROCS+1];

  logic [ID_W-1:0]      h_id;
  logic [TIME_BITS-1:0] h_need;
  logic [TIME_BITS-1:0] h_done;
  logic [PRIO_W-1:0]    h_prio;
  logic [TIME_BITS-1:0] h_done_inc;
  logic [PRIO_W-1:0]    h_prio_aged;
  logic                 h_fin;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign need_sat = (32'(need_time_i) > TMaxI) ? TMaxC : TIME_BITS'(need_time_i);

  assign {h_id, h_need, h_done, h_prio} = cell_ent[0];
  assign h_done_inc  = (h_done == TMaxC) ? h_done : h_done + TIME_BITS'(1);
  assign h_prio_aged = (!policy_q && (h_prio > PRIO_W'(1))) ? h_prio - PRIO_W'(1) : h_prio;
  assign h_fin       = (h_done_inc >= h_need);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    next_id_d = next_id_q;
    sorted_d  = sorted_q;
    phase_d   = phase_q;
    op        = OP_HOLD;
    ent_bus   = {h_id, h_need, h_done_inc, h_prio_aged};
    ran_d     = 1'b0;
    rid_d     = '0;
    rem_d     = '0;
    fin_d     = 1'b0;
    ref_d     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (mode_q) begin
          if (count_q == FullC) begin
            ref_d = 1'b1;
          end else begin
            op        = policy_q ? OP_INS_TAIL : OP_INS_PRIO;
            ent_bus   = {next_id_q, need_q, TIME_BITS'(0), prio_q};
            count_d   = count_q + CntW'(1);
            next_id_d = next_id_q + ID_W'(1);
            rid_d     = next_id_q;
            rem_d     = need_q;
            if (policy_q && (count_q != '0)) begin
              sorted_d = 1'b0;
            end
          end
        end else if (count_q != '0) begin
          ran_d   = 1'b1;
          rid_d   = h_id;
          rem_d   = h_fin ? '0 : h_need - h_done_inc;
          fin_d   = h_fin;
          count_d = count_q - CntW'(h_fin);
          if (h_fin) begin
            op = OP_REMOVE;
          end else if (policy_q) begin
            op       = OP_ROTATE;
            sorted_d = 1'b0;
          end else if (sorted_q) begin
            op = OP_REINSERT;
          end else begin
            op = OP_HEAD_WR;
          end
          if (!policy_q && !sorted_q) begin
            state_d = ST_SORT;
            phase_d = '0;
          end
        end
        if (count_d <= CntW'(1)) begin
          sorted_d = 1'b1;
        end
      end
      ST_SORT: begin
        op      = phase_q[0] ? OP_SORT_ODD : OP_SORT_EVEN;
        phase_d = phase_q + PhW'(1);
        if (phase_q == LastPhC) begin
          state_d  = ST_IDLE;
          sorted_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign carry[0] = 1'b0;

  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
    logic [EntW-1:0] left_w;
    logic [EntW-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_ent[k-1];
    end
    if (k == MAX_PROCS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_ent[k+1];
    end
    rls_cell #(
      .IDX       (k),
      .TIME_BITS (TIME_BITS),
      .CNT_W     (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .count_i (count_q),
      .carry_i (carry[k]),
      .carry_o (carry[k+1]),
      .ent_i   (ent_bus),
      .left_i  (left_w),
      .right_i (right_w),
      .ent_o   (cell_ent[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      policy_q  <= 1'b0;
      count_q   <= '0;
      next_id_q <= '0;
      sorted_q  <= 1'b1;
      phase_q   <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      sorted_q  <= sorted_d;
      phase_q   <= phase_d;
      strobe_q  <= (state_q == ST_EXEC);
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_policy_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      need_q <= need_sat;
      prio_q <= priority_req_i;
    end
    if (state_q == ST_EXEC) begin
      ran_q <= ran_d;
      rid_q <= rid_d;
      rem_q <= rem_d;
      fin_q <= fin_d;
      ref_q <= ref_d;
      ready_count_o <= COUNT_W'(count_d);
    end
  end

  assign result_valid_o  = strobe_q;
  assign ran_o           = ran_q;
  assign run_id_o        = rid_q;
  assign run_remaining_o = NEED_W'(rem_q);
  assign finished_o      = fin_q;
  assign add_refused_o   = ref_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullC)
    else $error("entry count above list depth");

  a_strobe_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result word without an executed item");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && add_refused_o) |->
      (!ran_o && (ready_count_o == COUNT_W'(MAX_PROCS))))
    else $error("add refused on a list that is not full");

  a_finish_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && finished_o) |-> ran_o)
    else $error("finish flagged without a run");

  a_sort_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT && phase_q == LastPhC) |=> (sorted_q && state_q == ST_IDLE))
    else $error("sort pass did not close");

endmodule

`default_nettype wire

>>> design/rls_cell.sv
`default_nettype none

module rls_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned TIME_BITS = 8,
  parameter int unsigned CNT_W     = 5,
  localparam int unsigned EntW     = rls_pkg::ID_W + 2 * TIME_BITS + rls_pkg::PRIO_W
) (
  input  wire logic                 clk_i,
  input  wire rls_pkg::rls_op_e     op_i,
  input  wire logic [CNT_W-1:0]     count_i,
  input  wire logic                 carry_i,
  output logic                      carry_o,
  input  wire logic [EntW-1:0]      ent_i,
  input  wire logic [EntW-1:0]      left_i,
  input  wire logic [EntW-1:0]      right_i,
  output logic [EntW-1:0]           ent_o
);
  import rls_pkg::*;

  localparam logic [CNT_W-1:0] IdxC   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NextC  = CNT_W'(IDX + 1);
  localparam bit               IsHead = (IDX == 0);
  localparam bit               IsOdd  = ((IDX % 2) == 1);

  logic [EntW-1:0]   ent_q;
  logic [EntW-1:0]   ent_d;
  logic [PRIO_W-1:0] prio_s;
  logic [PRIO_W-1:0] prio_l;
  logic [PRIO_W-1:0] prio_r;
  logic [PRIO_W-1:0] prio_e;
  logic              valid_s;
  logic              valid_r;
  logic              match;
  logic              gt_next;
  logic              odd_phase;

  assign prio_s  = ent_q[PRIO_W-1:0];
  assign prio_l  = left_i[PRIO_W-1:0];
  assign prio_r  = right_i[PRIO_W-1:0];
  assign prio_e  = ent_i[PRIO_W-1:0];
  assign valid_s = (count_i > IdxC);
  assign valid_r = (count_i > NextC);

  assign match   = (count_i == IdxC) ||
                   ((op_i == OP_INS_PRIO) && valid_s && (prio_s < prio_e));
  assign carry_o = carry_i | match;
  assign gt_next = valid_r && (prio_r > prio_e);
  assign odd_phase = (op_i == OP_SORT_ODD);

  always_comb begin
    ent_d = ent_q;
    unique case (op_i)
      OP_HOLD: begin
        ent_d = ent_q;
      end
      OP_INS_PRIO, OP_INS_TAIL: begin
        if (carry_i) begin
          ent_d = left_i;
        end else if (match) begin
          ent_d = ent_i;
        end
      end
      OP_REMOVE: begin
        ent_d = right_i;
      end
      OP_ROTATE: begin
        ent_d = (count_i == NextC) ? ent_i : right_i;
      end
      OP_REINSERT: begin
        if (gt_next) begin
          ent_d = right_i;
        end else if (IsHead || (prio_s > prio_e)) begin
          ent_d = ent_i;
        end
      end
      OP_HEAD_WR: begin
        if (IsHead) begin
          ent_d = ent_i;
        end
      end
      OP_SORT_EVEN, OP_SORT_ODD: begin
        if (IsOdd == odd_phase) begin
          if (valid_r && (prio_s < prio_r)) begin
            ent_d = right_i;
          end
        end else if (!IsHead) begin
          if (valid_s && (prio_l < prio_s)) begin
            ent_d = left_i;
          end
        end
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire
